// File: hw/rtl/tmt_pkg.sv
`default_nettype none
package tmt_pkg;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = 7;

  localparam logic [1:0] OpReport = 2'd0;
  localparam logic [1:0] OpSweep  = 2'd1;
  localparam logic [1:0] OpFlush  = 2'd2;

  localparam logic [2:0] ActAddRedirect  = 3'd0;
  localparam logic [2:0] ActAddBlackhole = 3'd1;
  localparam logic [2:0] ActDelRedirect  = 3'd2;
  localparam logic [2:0] ActDelBlackhole = 3'd3;
  localparam logic [2:0] ActDone         = 3'd4;

  localparam logic [2:0] RegInterval  = 3'd0;
  localparam logic [2:0] RegRedirect  = 3'd1;
  localparam logic [2:0] RegBlackhole = 3'd2;
  localparam logic [2:0] RegClear     = 3'd3;
  localparam logic [2:0] RegMinActive = 3'd4;
  localparam logic [2:0] RegStable    = 3'd5;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic div_start;  // start rate division
    logic scan;       // examine entry at scan index
    logic scan_next;  // advance scan index
    logic report_act; // apply report decision
    logic sweep_end;  // clear seen marks
  } tmt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic scan_last;
  } tmt_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/tmt_div.sv
`default_nettype none
// Restoring divider: 64-bit dividend by 12-bit divisor, one quotient bit a cycle.
module tmt_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [11:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [12:0] rem_q, rem_d;
  logic [11:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [12:0] trial;

  // shift in next dividend bit and try subtraction
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[11:0], quot_q[63]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = (divisor_i == 12'd0) ? 12'd1 : divisor_i;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd63);
  assign quot_o = quot_d;
endmodule
`default_nettype wire

// File: hw/rtl/tmt_datapath.sv
`default_nettype none
module tmt_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tmt_pkg::tmt_cmd_t cmd_i,
  output tmt_pkg::tmt_sts_t      sts_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [31:0]       dest_addr_i,
  input  wire logic [63:0]       byte_count_i,
  input  wire logic [63:0]       now_seconds_i,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [63:0]       cfg_data_i,
  output logic                   ev_valid_o,
  output logic [2:0]             ev_action_o,
  output logic                   ev_two_o,
  output logic [31:0]            ev_addr_o,
  output logic [6:0]             ev_count_o,
  output logic [1:0]             op_o
);
  import tmt_pkg::*;

  logic [11:0] intv_q;
  logic [63:0] redir_q, bh_q, clr_q;
  logic [31:0] minact_q, stable_q;

  logic [1:0]  op_q;
  logic [31:0] addr_q;
  logic [63:0] bytes_q, now_q, bps_q;

  logic [TableEntries-1:0] valid_q, seen_q;
  logic [31:0] e_addr_q [TableEntries];
  logic        e_bh_q   [TableEntries];
  logic [63:0] e_start_q[TableEntries];
  logic [63:0] e_below_q[TableEntries];
  logic [CntW-1:0] total_q;
  logic [IdxW-1:0] scan_q;

  logic        div_done;
  logic [63:0] quot;

  tmt_div u_div (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(bytes_q),
    .divisor_i (intv_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intv_q   <= 12'd1;
      redir_q  <= 64'd1000000000;
      bh_q     <= 64'd10000000000;
      clr_q    <= 64'd500000000;
      minact_q <= 32'd60;
      stable_q <= 32'd120;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInterval:  intv_q   <= cfg_data_i[11:0];
        RegRedirect:  redir_q  <= cfg_data_i;
        RegBlackhole: bh_q     <= cfg_data_i;
        RegClear:     clr_q    <= cfg_data_i;
        RegMinActive: minact_q <= cfg_data_i[31:0];
        RegStable:    stable_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // capture beat, rate
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= dest_addr_i;
      bytes_q <= byte_count_i;
      now_q   <= now_seconds_i;
    end
    if (div_done) bps_q <= {quot[60:0], 3'b000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) op_q <= 2'd0;
    else if (cmd_i.load) op_q <= op_i;
  end

  // match and free search over the table
  logic [TableEntries-1:0] hit_vec;
  logic            hit, free_any;
  logic [IdxW-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (e_addr_q[i] == addr_q);
      if (hit_vec[i]) begin hit = 1'b1; hit_idx = IdxW'(i); end
      if (!valid_q[i]) begin free_any = 1'b1; free_idx = IdxW'(i); end
    end
  end

  logic want_bh, want_rd, calm;
  assign want_bh = bps_q >= bh_q;
  assign want_rd = bps_q >= redir_q;
  assign calm    = bps_q < clr_q;

  // sweep and flush decision for scan entry
  logic [63:0] age, calm_time;
  logic        s_valid, s_old, s_remove, s_mark;
  assign s_valid   = valid_q[scan_q];
  assign age       = now_q - e_start_q[scan_q];
  assign calm_time = now_q - e_below_q[scan_q];
  assign s_old     = age >= {32'd0, minact_q};
  always_comb begin
    s_remove = 1'b0;
    s_mark   = 1'b0;
    if (op_q == OpFlush) s_remove = s_valid;
    else if (s_valid && s_old) begin
      if (e_below_q[scan_q] == 64'd0) s_mark = !seen_q[scan_q];
      else s_remove = calm_time >= {32'd0, stable_q};
    end
  end

  // event generation
  always_comb begin
    ev_valid_o  = 1'b0;
    ev_action_o = ActDone;
    ev_two_o    = 1'b0;
    ev_addr_o   = addr_q;
    if (cmd_i.report_act && (want_bh || want_rd)) begin
      if (!hit) begin
        ev_valid_o  = free_any;
        ev_action_o = want_bh ? ActAddBlackhole : ActAddRedirect;
      end else if (e_bh_q[hit_idx] != want_bh) begin
        ev_valid_o  = 1'b1;
        ev_two_o    = 1'b1;
        ev_action_o = want_bh ? ActDelRedirect : ActDelBlackhole;
      end
    end else if (cmd_i.scan && s_remove) begin
      ev_valid_o  = 1'b1;
      ev_action_o = e_bh_q[scan_q] ? ActDelBlackhole : ActDelRedirect;
      ev_addr_o   = e_addr_q[scan_q];
    end
  end

  logic [CntW-1:0] total_d;
  always_comb begin
    total_d = total_q;
    if (ev_valid_o && !ev_two_o) begin
      if (ev_action_o == ActAddBlackhole || ev_action_o == ActAddRedirect)
        total_d = total_q + 7'd1;
      else if (total_q != '0)
        total_d = total_q - 7'd1;
    end
  end
  assign ev_count_o = total_d;

  // table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      seen_q  <= '0;
      total_q <= '0;
      scan_q  <= '0;
    end else begin
      total_q <= total_d;
      if (cmd_i.load) scan_q <= '0;
      else if (cmd_i.scan_next) scan_q <= scan_q + IdxW'(1);
      if (cmd_i.report_act) begin
        if (hit) seen_q[hit_idx] <= 1'b1;
        else if ((want_bh || want_rd) && free_any) begin
          valid_q[free_idx] <= 1'b1;
          seen_q[free_idx]  <= 1'b1;
        end
      end
      if (cmd_i.scan && s_remove) begin
        valid_q[scan_q] <= 1'b0;
        seen_q[scan_q]  <= 1'b0;
      end
      if (cmd_i.sweep_end) seen_q <= '0;
    end
  end

  // table payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.report_act) begin
      if (want_bh || want_rd) begin
        if (!hit) begin
          if (free_any) begin
            e_addr_q[free_idx]  <= addr_q;
            e_bh_q[free_idx]    <= want_bh;
            e_start_q[free_idx] <= now_q;
            e_below_q[free_idx] <= 64'd0;
          end
        end else begin
          e_bh_q[hit_idx]    <= want_bh;
          e_below_q[hit_idx] <= 64'd0;
        end
      end else if (hit) begin
        if (!calm) e_below_q[hit_idx] <= 64'd0;
        else if (e_below_q[hit_idx] == 64'd0) e_below_q[hit_idx] <= now_q;
      end
    end
    if (cmd_i.scan && s_mark) e_below_q[scan_q] <= now_q;
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.scan_last = (scan_q == IdxW'(TableEntries - 1));
  assign op_o = op_q;
endmodule
`default_nettype wire

// File: hw/rtl/tmt_ctrl.sv
`default_nettype none
module tmt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        op_i,
  input  wire tmt_pkg::tmt_sts_t sts_i,
  output tmt_pkg::tmt_cmd_t      cmd_o,
  input  wire logic              ev_valid_i,
  input  wire logic [2:0]        ev_action_i,
  input  wire logic              ev_two_i,
  input  wire logic [31:0]       ev_addr_i,
  input  wire logic [6:0]        ev_count_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             action_o,
  output logic [31:0]            rule_addr_o,
  output logic [6:0]             active_count_o,
  output logic                   last_o
);
  import tmt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StAct   = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;
  localparam logic [2:0] StWait  = 3'd6;

  logic [2:0] state_q, state_d, ret_q, ret_d;
  logic       ov_q, ov_d, last_q, last_d, two_q, two_d;
  logic [2:0] act_q, act_d;
  logic [31:0] addr_q, addr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        free;

  assign free = !ov_q || out_ready_i;

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    ov_d = ov_q && !out_ready_i;
    last_d = last_q; act_d = act_q; addr_d = addr_q; cnt_d = cnt_q; two_d = two_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StStart;
        end
      end
      StStart: begin
        if (op_i == OpReport) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else if (op_i == OpSweep || op_i == OpFlush) state_d = StScan;
        else state_d = StDone;
      end
      StDiv: if (sts_i.div_done) state_d = StAct;
      StAct: if (free) begin
        cmd_o.report_act = 1'b1;
        state_d = StDone;
        if (ev_valid_i) begin
          ov_d = 1'b1; last_d = 1'b0; act_d = ev_action_i;
          addr_d = ev_addr_i; cnt_d = ev_count_i; two_d = ev_two_i;
          state_d = ev_two_i ? StWait : StDone;
          ret_d = StDone;
        end
      end
      StScan: if (free) begin
        cmd_o.scan = 1'b1;
        cmd_o.scan_next = 1'b1;
        if (ev_valid_i) begin
          ov_d = 1'b1; last_d = 1'b0; act_d = ev_action_i;
          addr_d = ev_addr_i; cnt_d = ev_count_i; two_d = 1'b0;
        end
        if (sts_i.scan_last) begin
          cmd_o.sweep_end = 1'b1;
          state_d = StDone;
        end
      end
      StWait: if (free) begin
        // second half of a kind change: add for the new kind
        ov_d = 1'b1; last_d = 1'b0;
        act_d = (act_q == ActDelRedirect) ? ActAddBlackhole : ActAddRedirect;
        state_d = ret_q;
      end
      StDone: if (free) begin
        ov_d = 1'b1; last_d = 1'b1; act_d = ActDone; addr_d = '0;
        cnt_d = ev_count_i;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ret_q <= StIdle; ov_q <= 1'b0; two_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; ov_q <= ov_d; two_q <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d; act_q <= act_d; addr_q <= addr_d; cnt_q <= cnt_d;
  end

  assign out_valid_o    = ov_q;
  assign action_o       = act_q;
  assign rule_addr_o    = addr_q;
  assign active_count_o = cnt_q;
  assign last_o         = last_q;
endmodule
`default_nettype wire

// File: hw/rtl/traffic_mitigation_table_top.sv
// Report: the bit-serial rate divider runs before the decision and the done beat;
//   sweep and flush examine one table entry per cycle while the output is free, then give the done beat.
// Throughput: one item at a time; next item accepted after the done beat is issued.
// Reset: asynchronous active low; clears valid and seen marks and count, restores config defaults.
`default_nettype none
module traffic_mitigation_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] dest_addr_i,
  input  wire logic [63:0] byte_count_i,
  input  wire logic [63:0] now_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       action_o,
  output logic [31:0]      rule_addr_o,
  output logic [6:0]       active_count_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);
  import tmt_pkg::*;

  tmt_cmd_t   cmd;
  tmt_sts_t   sts;
  logic       ev_valid, ev_two;
  logic [2:0] ev_action;
  logic [31:0] ev_addr;
  logic [6:0]  ev_count;
  logic [1:0]  op_q;

  tmt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i, .dest_addr_i, .byte_count_i, .now_seconds_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ev_valid_o(ev_valid), .ev_action_o(ev_action), .ev_two_o(ev_two),
    .ev_addr_o(ev_addr), .ev_count_o(ev_count), .op_o(op_q)
  );

  tmt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i(op_q),
    .sts_i(sts), .cmd_o(cmd),
    .ev_valid_i(ev_valid), .ev_action_i(ev_action), .ev_two_i(ev_two),
    .ev_addr_i(ev_addr), .ev_count_i(ev_count),
    .out_valid_o, .out_ready_i, .action_o, .rule_addr_o, .active_count_o, .last_o
  );

  // no new beat while a non-done result is pending from the controller
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> !in_ready_o) else $error("accept while busy");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_count_o <= 7'(TableEntries))) else $error("count range");
  a_done_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (action_o == ActDone && rule_addr_o == 32'd0))
    else $error("done beat malformed");
endmodule
`default_nettype wire

// File: bench/tb_traffic_mitigation_table_top.sv
`default_nettype none
module tb_traffic_mitigation_table_top;
  import tmt_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [31:0] dest_addr_i = '0;
  logic [63:0] byte_count_i = '0;
  logic [63:0] now_seconds_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  action_o;
  logic [31:0] rule_addr_o;
  logic [6:0]  active_count_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  traffic_mitigation_table_top i_dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] addr;
    logic [6:0]  count;
    logic        last;
  } rule_beat_t;

  // predictor copy of configuration and table
  logic [11:0] m_interval;
  logic [63:0] m_redirect, m_blackhole, m_clear;
  logic [31:0] m_min_active, m_stable;
  logic        m_valid [TableEntries];
  logic [31:0] m_addr [TableEntries];
  logic        m_bh [TableEntries];
  logic [63:0] m_start [TableEntries];
  logic [63:0] m_below [TableEntries];
  logic        m_seen [TableEntries];
  logic [6:0]  m_active;

  rule_beat_t  expected_rules [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;
  logic [63:0] clock_now = 64'd1000;
  logic [31:0] addr_pool [8];

  // count cycles, hold the run to a limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // drive ready with random idling or a long hold-off
  always @(posedge clk_i) begin
    if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    rule_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rules.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat action=%0d addr=%h", action_o, rule_addr_o);
      end else begin
        exp_beat = expected_rules.pop_front();
        if (exp_beat != {action_o, rule_addr_o, active_count_o, last_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp act=%0d addr=%h cnt=%0d last=%0d got act=%0d addr=%h cnt=%0d last=%0d",
                     exp_beat.action, exp_beat.addr, exp_beat.count, exp_beat.last,
                     action_o, rule_addr_o, active_count_o, last_o);
        end
      end
    end
  end

  function automatic void push_rule(logic [2:0] act, logic [31:0] addr, logic last);
    expected_rules.push_back('{act, addr, m_active, last});
  endfunction

  function automatic void drop_slot(int i);
    m_valid[i] = 1'b0;
    m_seen[i] = 1'b0;
    if (m_active != 0) m_active--;
    push_rule(m_bh[i] ? ActDelBlackhole : ActDelRedirect, m_addr[i], 1'b0);
  endfunction

  function automatic void mitigate(int idx, logic [31:0] addr, logic [63:0] now, logic bh);
    int slot;
    slot = -1;
    if (idx < 0) begin
      for (int i = 0; i < TableEntries; i++)
        if (!m_valid[i] && slot < 0) slot = i;
      if (slot < 0) return;
      m_valid[slot] = 1'b1;
      m_addr[slot] = addr;
      m_bh[slot] = bh;
      m_start[slot] = now;
      m_below[slot] = '0;
      m_seen[slot] = 1'b1;
      m_active++;
      push_rule(bh ? ActAddBlackhole : ActAddRedirect, addr, 1'b0);
      return;
    end
    if (m_bh[idx] != bh) begin
      push_rule(bh ? ActDelRedirect : ActDelBlackhole, addr, 1'b0);
      push_rule(bh ? ActAddBlackhole : ActAddRedirect, addr, 1'b0);
      m_bh[idx] = bh;
    end
    m_below[idx] = '0;
  endfunction

  // predict the beats one item causes
  function automatic void predict_item(logic [1:0] op, logic [31:0] addr,
                                       logic [63:0] bytes, logic [63:0] now);
    logic [63:0] bps;
    logic [63:0] div;
    int idx;
    idx = -1;
    if (op == OpReport) begin
      div = (m_interval == 0) ? 64'd1 : {52'd0, m_interval};
      bps = (bytes / div) << 3;
      for (int i = TableEntries - 1; i >= 0; i--)
        if (m_valid[i] && m_addr[i] == addr) idx = i;
      if (idx >= 0) m_seen[idx] = 1'b1;
      if (bps >= m_blackhole) mitigate(idx, addr, now, 1'b1);
      else if (bps >= m_redirect) mitigate(idx, addr, now, 1'b0);
      else if (idx >= 0) begin
        if (bps < m_clear) begin
          if (m_below[idx] == 0) m_below[idx] = now;
        end else begin
          m_below[idx] = '0;
        end
      end
    end else if (op == OpSweep) begin
      for (int i = 0; i < TableEntries; i++) begin
        if (m_valid[i] && (now - m_start[i]) >= {32'd0, m_min_active}) begin
          if (m_below[i] == 0) begin
            if (!m_seen[i]) m_below[i] = now;
          end else if ((now - m_below[i]) >= {32'd0, m_stable}) begin
            drop_slot(i);
          end
        end
      end
      for (int i = 0; i < TableEntries; i++) m_seen[i] = 1'b0;
    end else if (op == OpFlush) begin
      for (int i = 0; i < TableEntries; i++) begin
        if (m_valid[i]) drop_slot(i);
        m_seen[i] = 1'b0;
      end
    end
    push_rule(ActDone, '0, 1'b1);
  endfunction

  // offer one beat, predict it once accepted
  task automatic send_item(logic [1:0] op, logic [31:0] addr, logic [63:0] bytes,
                           logic [63:0] now);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= op;
    dest_addr_i <= addr;
    byte_count_i <= bytes;
    now_seconds_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(op, addr, bytes, now);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_rules.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [63:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegInterval:  m_interval = value[11:0];
      RegRedirect:  m_redirect = value;
      RegBlackhole: m_blackhole = value;
      RegClear:     m_clear = value;
      RegMinActive: m_min_active = value[31:0];
      RegStable:    m_stable = value[31:0];
      default: ;
    endcase
  endtask

  // small scaled thresholds keep byte counts readable
  task automatic set_config(logic [11:0] intv, logic [63:0] rd, logic [63:0] bh,
                            logic [63:0] clr, logic [31:0] mina, logic [31:0] stab);
    wait_drained();
    write_cfg(RegInterval, {52'd0, intv});
    write_cfg(RegRedirect, rd);
    write_cfg(RegBlackhole, bh);
    write_cfg(RegClear, clr);
    write_cfg(RegMinActive, {32'd0, mina});
    write_cfg(RegStable, {32'd0, stab});
  endtask

  task automatic test_directed();
    set_config(12'd1, 64'd1000, 64'd10000, 64'd500, 32'd10, 32'd20);
    send_item(OpReport, 32'h0a000001, 64'd200, 64'd100);    // redirect add
    send_item(OpReport, 32'h0a000001, 64'd2000, 64'd101);   // escalate
    send_item(OpReport, 32'h0a000001, 64'd200, 64'd102);    // de-escalate
    send_item(OpReport, 32'h0a000001, 64'd10, 64'd103);     // start calm time
    send_item(OpReport, 32'h0a000001, 64'd70, 64'd104);     // clear calm time
    send_item(OpReport, 32'hffffffff, 64'hffffffffffffffff, 64'hffffffffffffffff);
    send_item(OpReport, 32'h00000000, 64'd0, 64'd0);        // below all, no entry
    send_item(2'd3, 32'h1, 64'd5000, 64'd5);                // unknown op
    send_item(OpSweep, '0, '0, 64'd200);
    send_item(OpSweep, '0, '0, 64'd300);
    send_item(OpSweep, '0, '0, 64'd0);                      // wrapped age, time zero
    for (int i = 0; i < 18; i++)                            // fill past full
      send_item(OpReport, 32'hc0a80000 + i, 64'd3000, 64'd0);
    send_item(OpSweep, '0, '0, 64'd0);                      // sweep at time zero, new entries too young to mark
    send_item(OpFlush, '0, '0, '0);
    send_item(OpFlush, '0, '0, '0);
  endtask

  task automatic test_random(int n);
    logic [1:0]  op;
    logic [31:0] addr;
    logic [63:0] bytes;
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      clock_now = clock_now + $urandom_range(40);
      addr = ($urandom_range(9) == 0) ? $urandom : addr_pool[$urandom_range(7)];
      case ($urandom_range(3))
        0: bytes = 64'($urandom_range(60));
        1: bytes = 64'($urandom_range(1000));
        2: bytes = 64'($urandom_range(20000));
        default: bytes = {$urandom, $urandom};
      endcase
      if (sel < 70) op = OpReport;
      else if (sel < 92) op = OpSweep;
      else if (sel < 96) op = OpFlush;
      else op = 2'd3;
      send_item(op, addr, bytes, ($urandom_range(19) == 0) ? {$urandom, $urandom} : clock_now);
    end
  endtask

  task automatic test_backpressure();
    recv_hold = 600;
    for (int i = 0; i < 6; i++)
      send_item(OpReport, 32'h0b000000 + i, 64'd50000, clock_now);
    wait_drained();
    send_item(OpFlush, '0, '0, '0);
  endtask

  initial begin
    m_interval = 12'd1;
    m_redirect = 64'd1000000000;
    m_blackhole = 64'd10000000000;
    m_clear = 64'd500000000;
    m_min_active = 32'd60;
    m_stable = 32'd120;
    m_active = '0;
    for (int i = 0; i < TableEntries; i++) begin
      m_valid[i] = 1'b0; m_seen[i] = 1'b0; m_bh[i] = 1'b0;
      m_addr[i] = '0; m_start[i] = '0; m_below[i] = '0;
    end
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 12; recv_idle_pct = 54;
    test_directed();
    set_config(12'd4, 64'd800, 64'd16000, 64'd200, 32'd30, 32'd50);
    test_random(30);
    test_backpressure();
    send_idle_pct = 54; recv_idle_pct = 12;
    set_config(12'd0, 64'd0, 64'hffffffffffffffff, 64'd0, 32'd0, 32'd0);
    test_random(15);
    set_config(12'd4095, 64'd40, 64'd400, 64'd16, 32'hffffffff, 32'hffffffff);
    test_random(15);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_config(12'd2, 64'd2000, 64'd40000, 64'd1000, 32'd20, 32'd40);
    test_random(30);

    wait_drained();
    if (mismatches == 0 && expected_rules.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/tmt_pkg.sv
hw/rtl/tmt_div.sv
hw/rtl/tmt_datapath.sv
hw/rtl/tmt_ctrl.sv
hw/rtl/traffic_mitigation_table_top.sv
bench/tb_traffic_mitigation_table_top.sv
